// ===== rtl/core/cpv_pkg.sv =====
// ----------------------------------------------------------------------------
// cpv_pkg
// Shared types, constants and saturation helpers for the cascade PID block.
// ----------------------------------------------------------------------------
`default_nettype none

package cpv_pkg;

  localparam int DATA_W    = 32;
  localparam int LIM_W     = 31;
  localparam int CFG_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KI  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_LIM = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_LIM = 3'd7;

  // register reset values
  localparam logic signed [DATA_W-1:0] RST_OUTER_KP  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] RST_OUTER_KI  = 32'sd0;
  localparam logic signed [DATA_W-1:0] RST_OUTER_KD  = 32'sd65536;
  localparam logic signed [DATA_W-1:0] RST_INNER_KP  = 32'sd6554;
  localparam logic signed [DATA_W-1:0] RST_INNER_KI  = 32'sd655;
  localparam logic signed [DATA_W-1:0] RST_INNER_KD  = 32'sd0;
  localparam logic [LIM_W-1:0]         RST_OUTER_LIM = 31'd786432;
  localparam logic [LIM_W-1:0]         RST_INNER_LIM = 31'd393216;

  // integral magnitude limits, one per stage
  localparam logic signed [DATA_W:0] OUTER_INT_LIMIT = 33'sd0;
  localparam logic signed [DATA_W:0] INNER_INT_LIMIT = 33'sd65536000;

  localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic signed [DATA_W-1:0] position_target;
    logic signed [DATA_W-1:0] position_measured;
    logic signed [DATA_W-1:0] velocity_measured;
  } cpv_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] velocity_setpoint;
    logic signed [DATA_W-1:0] drive_voltage;
  } cpv_out_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] outer_kp;
    logic signed [DATA_W-1:0] outer_ki;
    logic signed [DATA_W-1:0] outer_kd;
    logic signed [DATA_W-1:0] inner_kp;
    logic signed [DATA_W-1:0] inner_ki;
    logic signed [DATA_W-1:0] inner_kd;
    logic [LIM_W-1:0]         outer_out_limit;
    logic [LIM_W-1:0]         inner_out_limit;
  } cpv_cfg_t;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_ERR   = 8'b0000_0010,
    ST_MUL_P = 8'b0000_0100,
    ST_MUL_I = 8'b0000_1000,
    ST_MUL_D = 8'b0001_0000,
    ST_SUM   = 8'b0010_0000,
    ST_LIM   = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } cpv_state_t;

  localparam logic STAGE_OUTER = 1'b0;
  localparam logic STAGE_INNER = 1'b1;

  typedef struct packed {
    logic load_in;
    logic stage;
    logic calc_err;
    logic mul_p;
    logic mul_i;
    logic mul_d;
    logic add_sum;
    logic clamp_out;
    logic load_out;
  } cpv_cmd_t;

  // saturate a 34-bit signed value to s32
  function automatic logic signed [DATA_W-1:0] sat34(input logic signed [DATA_W+1:0] x);
    logic signed [DATA_W-1:0] r;
    if (!x[DATA_W+1] && (|x[DATA_W:DATA_W-1]))
      r = S32_MAX;
    else if (x[DATA_W+1] && !(&x[DATA_W:DATA_W-1]))
      r = S32_MIN;
    else
      r = x[DATA_W-1:0];
    return r;
  endfunction

  // Q16.16 product: floor(p / 2^16) saturated to s32
  function automatic logic signed [DATA_W-1:0] q16(input logic signed [2*DATA_W-1:0] p);
    logic signed [DATA_W-1:0] r;
    if (!p[63] && (|p[62:47]))
      r = S32_MAX;
    else if (p[63] && !(&p[62:47]))
      r = S32_MIN;
    else
      r = p[47:16];
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cpv_ctrl.sv =====
// ----------------------------------------------------------------------------
// cpv_ctrl
// Sequencer: steps both PID stages through the shared datapath and owns the
// input/output handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module cpv_ctrl
  import cpv_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output cpv_cmd_t  cmd
);

  cpv_state_t state_r, state_nxt;
  logic       stage_r, stage_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       emit_go;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign emit_go   = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    stage_nxt = stage_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_ERR;
          stage_nxt = STAGE_OUTER;
        end
      end
      ST_ERR:   state_nxt = ST_MUL_P;
      ST_MUL_P: state_nxt = ST_MUL_I;
      ST_MUL_I: state_nxt = ST_MUL_D;
      ST_MUL_D: state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_LIM;
      ST_LIM: begin
        if (stage_r == STAGE_OUTER) begin
          state_nxt = ST_ERR;
          stage_nxt = STAGE_INNER;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_go) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (emit_go) out_valid_nxt = 1'b1;
  end

  always_comb begin
    cmd.load_in   = (state_r == ST_IDLE) && in_valid;
    cmd.stage     = stage_r;
    cmd.calc_err  = (state_r == ST_ERR);
    cmd.mul_p     = (state_r == ST_MUL_P);
    cmd.mul_i     = (state_r == ST_MUL_I);
    cmd.mul_d     = (state_r == ST_MUL_D);
    cmd.add_sum   = (state_r == ST_SUM);
    cmd.clamp_out = (state_r == ST_LIM);
    cmd.load_out  = emit_go;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= STAGE_OUTER;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/cpv_dp.sv =====
// ----------------------------------------------------------------------------
// cpv_dp
// Datapath: one shared 32x32 multiplier with registered product, error and
// sum adders, saturation and clamps, and the per-stage PID state.
// ----------------------------------------------------------------------------
`default_nettype none

module cpv_dp
  import cpv_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cpv_cmd_t cmd,
  input  wire cpv_in_t  in_data,
  input  wire cpv_cfg_t cfg,
  output cpv_out_t      out_data
);

  // latched input item
  logic signed [DATA_W-1:0] tgt_r, pos_r, vel_r;
  // per-stage state
  logic signed [DATA_W-1:0] outer_prev_r, outer_integ_r, inner_prev_r, inner_integ_r;
  // working registers
  logic signed [DATA_W-1:0]   err_r, diff_r, p_r, vset_r, volt_r;
  logic signed [2*DATA_W-1:0] prod_r;
  logic signed [DATA_W+1:0]   sum_r;
  cpv_out_t                   out_r;

  // stage selection
  logic signed [DATA_W-1:0] ref_s, fdb_s, prev_s, integ_s, kp_s, ki_s, kd_s;
  logic signed [DATA_W:0]   int_lim_s, out_lim_s;
  logic signed [DATA_W-1:0] gain_s, opnd_s, q_s, err_s, diff_s, sat_s, res_s, integ_new;
  logic signed [DATA_W:0]   isum;

  always_comb begin
    if (cmd.stage == STAGE_INNER) begin
      ref_s     = vset_r;
      fdb_s     = vel_r;
      prev_s    = inner_prev_r;
      integ_s   = inner_integ_r;
      kp_s      = cfg.inner_kp;
      ki_s      = cfg.inner_ki;
      kd_s      = cfg.inner_kd;
      int_lim_s = INNER_INT_LIMIT;
      out_lim_s = {2'b00, cfg.inner_out_limit};
    end else begin
      ref_s     = tgt_r;
      fdb_s     = pos_r;
      prev_s    = outer_prev_r;
      integ_s   = outer_integ_r;
      kp_s      = cfg.outer_kp;
      ki_s      = cfg.outer_ki;
      kd_s      = cfg.outer_kd;
      int_lim_s = OUTER_INT_LIMIT;
      out_lim_s = {2'b00, cfg.outer_out_limit};
    end
  end

  assign err_s  = sat34({{2{ref_s[DATA_W-1]}}, ref_s} - {{2{fdb_s[DATA_W-1]}}, fdb_s});
  assign diff_s = sat34({{2{err_r[DATA_W-1]}}, err_r} - {{2{prev_s[DATA_W-1]}}, prev_s});

  // multiplier operand select
  always_comb begin
    if (cmd.mul_d) begin
      gain_s = kd_s;
      opnd_s = diff_r;
    end else if (cmd.mul_i) begin
      gain_s = ki_s;
      opnd_s = err_r;
    end else begin
      gain_s = kp_s;
      opnd_s = err_r;
    end
  end

  assign q_s = q16(prod_r);

  // integral update with magnitude clamp
  always_comb begin
    isum = {integ_s[DATA_W-1], integ_s} + {q_s[DATA_W-1], q_s};
    if (isum > int_lim_s)
      integ_new = int_lim_s[DATA_W-1:0];
    else if (isum < -int_lim_s)
      integ_new = DATA_W'(-int_lim_s);
    else
      integ_new = isum[DATA_W-1:0];
  end

  // saturated sum, then output clamp
  always_comb begin
    sat_s = sat34(sum_r);
    if ($signed({sat_s[DATA_W-1], sat_s}) > out_lim_s)
      res_s = out_lim_s[DATA_W-1:0];
    else if ($signed({sat_s[DATA_W-1], sat_s}) < -out_lim_s)
      res_s = DATA_W'(-out_lim_s);
    else
      res_s = sat_s;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      tgt_r <= in_data.position_target;
      pos_r <= in_data.position_measured;
      vel_r <= in_data.velocity_measured;
    end
    if (cmd.calc_err) err_r <= err_s;
    if (cmd.mul_p) diff_r <= diff_s;
    if (cmd.mul_p || cmd.mul_i || cmd.mul_d)
      prod_r <= (2*DATA_W)'(gain_s) * (2*DATA_W)'(opnd_s);
    if (cmd.mul_i) p_r <= q_s;
    if (cmd.add_sum)
      sum_r <= {{2{p_r[DATA_W-1]}}, p_r} + {{2{integ_s[DATA_W-1]}}, integ_s}
             + {{2{q_s[DATA_W-1]}}, q_s};
    if (cmd.clamp_out) begin
      if (cmd.stage == STAGE_INNER) volt_r <= res_s;
      else                          vset_r <= res_s;
    end
    if (cmd.load_out) begin
      out_r.velocity_setpoint <= vset_r;
      out_r.drive_voltage     <= volt_r;
    end
  end

  // PID history, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outer_prev_r  <= '0;
      outer_integ_r <= '0;
      inner_prev_r  <= '0;
      inner_integ_r <= '0;
    end else if (cmd.mul_d) begin
      if (cmd.stage == STAGE_INNER) begin
        inner_prev_r  <= err_r;
        inner_integ_r <= integ_new;
      end else begin
        outer_prev_r  <= err_r;
        outer_integ_r <= integ_new;
      end
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/cascade_pid_position_velocity.sv =====
// ----------------------------------------------------------------------------
// cascade_pid_position_velocity
// Position loop feeding a velocity loop, two positional PID stages in Q16.16.
//
// Input channel (in_valid/in_stall/in_data) carries one control tick:
// target position, measured position and measured velocity. Result channel
// (out_valid/out_stall/out_data) returns the velocity setpoint and drive
// voltage for that tick. Gains and output limits are written on the cfg_
// port (cfg_we, cfg_index, cfg_data); the user must write them only while
// the block is idle, which the block itself does not enforce. Each stage
// steps through six states, three of them on the single shared 32x32
// multiplier, and the stages run back to back. The finished result sits
// in an output register; only then is the next item taken, while it waits.
// If the receiver still stalls when the next result is ready, the sequencer
// holds it until the output register is free.
// Reset clears the integrators and previous errors, loads default gains and
// limits, and leaves both channels idle.
// ----------------------------------------------------------------------------
`default_nettype none

module cascade_pid_position_velocity
  import cpv_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire cpv_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output cpv_out_t                  out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [DATA_W-1:0]    cfg_data
);

  cpv_cfg_t cfg_r, cfg_nxt;
  cpv_cmd_t cmd;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_OUTER_KP:  cfg_nxt.outer_kp        = cfg_data;
        REG_OUTER_KI:  cfg_nxt.outer_ki        = cfg_data;
        REG_OUTER_KD:  cfg_nxt.outer_kd        = cfg_data;
        REG_INNER_KP:  cfg_nxt.inner_kp        = cfg_data;
        REG_INNER_KI:  cfg_nxt.inner_ki        = cfg_data;
        REG_INNER_KD:  cfg_nxt.inner_kd        = cfg_data;
        REG_OUTER_LIM: cfg_nxt.outer_out_limit = cfg_data[LIM_W-1:0];
        REG_INNER_LIM: cfg_nxt.inner_out_limit = cfg_data[LIM_W-1:0];
        default:       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.outer_kp        <= RST_OUTER_KP;
      cfg_r.outer_ki        <= RST_OUTER_KI;
      cfg_r.outer_kd        <= RST_OUTER_KD;
      cfg_r.inner_kp        <= RST_INNER_KP;
      cfg_r.inner_ki        <= RST_INNER_KI;
      cfg_r.inner_kd        <= RST_INNER_KD;
      cfg_r.outer_out_limit <= RST_OUTER_LIM;
      cfg_r.inner_out_limit <= RST_INNER_LIM;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  cpv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  cpv_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .out_data (out_data)
  );

  // a transfer in starts the sequence, so the input side is busy next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken but sequencer did not start");

  // delivered results respect the configured magnitude limits
  a_vset_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($signed({out_data.velocity_setpoint[DATA_W-1], out_data.velocity_setpoint})
         <= $signed({2'b00, cfg_r.outer_out_limit})) &&
      ($signed({out_data.velocity_setpoint[DATA_W-1], out_data.velocity_setpoint})
         >= -$signed({2'b00, cfg_r.outer_out_limit})))
    else $error("velocity setpoint outside its limit");

  a_volt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      ($signed({out_data.drive_voltage[DATA_W-1], out_data.drive_voltage})
         <= $signed({2'b00, cfg_r.inner_out_limit})) &&
      ($signed({out_data.drive_voltage[DATA_W-1], out_data.drive_voltage})
         >= -$signed({2'b00, cfg_r.inner_out_limit})))
    else $error("drive voltage outside its limit");

endmodule

`default_nettype wire
